@@ hdl/i2cra_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C register access master package
// Shared types and constants for the tick-driven I2C register master.
// ----------------------------------------------------------------------------
package i2cra_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_DEV_ADDR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACK_TMO = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PHASE = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PWM_BASE = 2'd3;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;
  localparam logic [1:0] MODE_PWM = 2'd3;

  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [7:0] READ_BIT = 8'h01;
  localparam logic [7:0] DEFAULT_ACK_TIMEOUT = 8'd250;
  localparam int unsigned CHANNEL_STRIDE = 4;
  localparam logic [3:0] PWM_LAST_BYTE = 4'd11;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  reg_addr;
    logic [7:0]  write_data;
    logic [3:0]  channel;
    logic [15:0] on_count;
    logic [15:0] off_count;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;
  } out_item_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] ack_timeout;
    logic [7:0] phase_ticks;
    logic [7:0] pwm_base_register;
  } cfg_t;

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_ST_A      = 16'h0002,
    S_ST_B      = 16'h0004,
    S_TX_SETUP  = 16'h0008,
    S_TX_HIGH   = 16'h0010,
    S_TX_LOW    = 16'h0020,
    S_ACK_REL   = 16'h0040,
    S_ACK_POLL  = 16'h0080,
    S_RS_LOW    = 16'h0100,
    S_RX_LOW    = 16'h0200,
    S_RX_HIGH   = 16'h0400,
    S_NACK_LOW  = 16'h0800,
    S_NACK_HIGH = 16'h1000,
    S_SP_A      = 16'h2000,
    S_SP_B      = 16'h4000,
    S_FIN       = 16'h8000
  } seq_t;

endpackage

@@ hdl/i2cra_fifo.sv @@
// ----------------------------------------------------------------------------
// I2C register access queue
// Small register-based queue that decouples the tick front and result back.
// ----------------------------------------------------------------------------
module i2cra_fifo
  import i2cra_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t din,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output out_item_t dout
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  out_item_t mem_r [Depth];
  logic [PtrW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PtrW:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full = (cnt_r == (PtrW+1)'(Depth));
  assign empty = (cnt_r == '0);
  assign dout = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PtrW'(Depth - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PtrW'(Depth - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end
endmodule

@@ hdl/i2cra_seq.sv @@
// ----------------------------------------------------------------------------
// I2C register access sequencer
// Per-tick bus sequencer: latches commands and steps the I2C waveform.
// ----------------------------------------------------------------------------
module i2cra_seq
  import i2cra_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      tick,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);
  seq_t        step_r, step_nxt, st;
  logic [2:0]  bit_r, bit_nxt;
  logic [3:0]  byte_r, byte_nxt, bidx;
  logic [8:0]  ph_r, ph_nxt, ph;
  logic [7:0]  wait_r, wait_nxt;
  logic [7:0]  sh_r, sh_nxt, sh;
  logic [7:0]  rx_r, rx_nxt;
  logic [7:0]  lreg_r, lreg_nxt, lreg;
  logic [7:0]  ldat_r, ldat_nxt, ldat;
  logic [15:0] lon_r, lon_nxt, lon;
  logic [15:0] loff_r, loff_nxt, loff;
  logic        err_r, err_nxt, err;
  logic [1:0]  kind_r, kind_nxt, kind;
  logic [7:0]  p;
  logic [8:0]  dur;
  logic        pend, accept, txlow;
  logic [7:0]  addr_w, nb;
  logic [1:0]  grp, pos;
  logic [3:0]  pwm_g;

  // In pwm mode the byte after an ACK continues while position is below two.
  function automatic logic false_pos(input logic [3:0] b);
    logic [3:0] r;
    r = (b >= 4'd9) ? b - 4'd9 : (b >= 4'd6) ? b - 4'd6 : (b >= 4'd3) ? b - 4'd3 : b;
    return r < 4'd2;
  endfunction

  assign p = (cfg.phase_ticks == '0) ? 8'd1 : cfg.phase_ticks;
  assign addr_w = {cfg.device_address, 1'b0};

  // Byte position within one PWM write (address, register, data) and group.
  always_comb begin
    pwm_g = 4'd0;
    pos = 2'd0;
    if (byte_nxt >= 4'd9) begin
      pwm_g = 4'd3; pos = 2'(byte_nxt - 4'd9);
    end else if (byte_nxt >= 4'd6) begin
      pwm_g = 4'd2; pos = 2'(byte_nxt - 4'd6);
    end else if (byte_nxt >= 4'd3) begin
      pwm_g = 4'd1; pos = 2'(byte_nxt - 4'd3);
    end else begin
      pos = 2'(byte_nxt);
    end
    grp = pwm_g[1:0];
  end

  // Byte for the next byte index (byte_nxt), selected by operation kind.
  always_comb begin
    nb = addr_w;
    case (kind)
      MODE_WRITE: nb = (byte_nxt == 4'd0) ? addr_w : ((byte_nxt == 4'd1) ? lreg : ldat);
      MODE_READ: nb = (byte_nxt == 4'd0) ? addr_w :
                      ((byte_nxt == 4'd1) ? lreg : (addr_w | READ_BIT));
      MODE_PWM: begin
        if (pos == 2'd0) begin
          nb = addr_w;
        end else if (pos == 2'd1) begin
          nb = lreg + {6'd0, grp};
        end else begin
          case (grp)
            2'd0: nb = lon[7:0];
            2'd1: nb = lon[15:8];
            2'd2: nb = loff[7:0];
            default: nb = loff[15:8];
          endcase
        end
      end
      default: nb = addr_w;
    endcase
  end

  always_comb begin
    accept = (step_r == S_IDLE) && (item.mode != MODE_TICK);
    st = step_r; bidx = byte_r; ph = ph_r; sh = sh_r;
    lreg = lreg_r; ldat = ldat_r; lon = lon_r; loff = loff_r;
    err = err_r; kind = kind_r;
    bit_nxt = bit_r; wait_nxt = wait_r; rx_nxt = rx_r;
    if (accept) begin
      kind = item.mode;
      lreg = (item.mode == MODE_PWM) ?
             8'(cfg.pwm_base_register + 8'(CHANNEL_STRIDE) * {4'd0, item.channel}) :
             item.reg_addr;
      ldat = item.write_data;
      lon = item.on_count;
      loff = item.off_count;
      err = 1'b0; bidx = '0; bit_nxt = '0; ph = '0; wait_nxt = '0;
      st = S_ST_A;
    end
    txlow = (sh & MSB_MASK) == '0;

    res.busy_res = 1'b1;
    res.done_res = 1'b0;
    res.scl_level = 1'b1;
    res.sda_pull_low = 1'b0;
    case (st)
      S_ST_A: begin end
      S_ST_B: res.sda_pull_low = 1'b1;
      S_TX_SETUP, S_TX_LOW: begin
        res.scl_level = 1'b0; res.sda_pull_low = txlow;
      end
      S_TX_HIGH: res.sda_pull_low = txlow;
      S_ACK_REL, S_RS_LOW, S_RX_LOW, S_NACK_LOW: res.scl_level = 1'b0;
      S_ACK_POLL, S_RX_HIGH, S_NACK_HIGH: begin end
      S_SP_A: begin
        res.scl_level = 1'b0; res.sda_pull_low = 1'b1;
      end
      S_SP_B: res.sda_pull_low = 1'b1;
      S_FIN: begin
        res.busy_res = 1'b0; res.done_res = 1'b1;
      end
      default: res.busy_res = 1'b0;
    endcase

    // Phase timing: long phases for start and stop, normal otherwise.
    dur = (st == S_ST_A || st == S_ST_B || st == S_SP_A || st == S_SP_B) ?
          {p, 1'b0} : {1'b0, p};
    pend = (ph + 9'd1) >= dur;
    ph_nxt = pend ? 9'd0 : ph + 9'd1;

    step_nxt = st; byte_nxt = bidx; sh_nxt = sh; err_nxt = err;
    case (st)
      S_ST_A: if (pend) step_nxt = S_ST_B;
      S_ST_B: if (pend) step_nxt = S_TX_SETUP;
      S_TX_SETUP: if (pend) step_nxt = S_TX_HIGH;
      S_TX_HIGH: if (pend) step_nxt = S_TX_LOW;
      S_TX_LOW: if (pend) begin
        if (bit_r == 3'd7) begin
          bit_nxt = '0; step_nxt = S_ACK_REL;
        end else begin
          bit_nxt = bit_r + 1'b1; sh_nxt = {sh[6:0], 1'b0}; step_nxt = S_TX_SETUP;
        end
      end
      S_ACK_REL: if (pend) begin
        wait_nxt = '0; step_nxt = S_ACK_POLL;
      end
      S_ACK_POLL: begin
        ph_nxt = ph;
        if (!item.sda_in) begin
          wait_nxt = '0;
          if (kind == MODE_READ) begin
            if (bidx == 4'd0) begin
              byte_nxt = 4'd1; step_nxt = S_TX_SETUP; bit_nxt = '0;
            end else if (bidx == 4'd1) begin
              byte_nxt = 4'd2; step_nxt = S_RS_LOW;
            end else begin
              bit_nxt = '0; sh_nxt = '0; step_nxt = S_RX_LOW;
            end
          end else if ((kind == MODE_WRITE && bidx < 4'd2) ||
                       (kind == MODE_PWM && false_pos(bidx))) begin
            byte_nxt = bidx + 1'b1; step_nxt = S_TX_SETUP; bit_nxt = '0;
          end else begin
            step_nxt = S_SP_A;
          end
        end else if (wait_r >= cfg.ack_timeout) begin
          err_nxt = 1'b1; wait_nxt = '0; step_nxt = S_SP_A;
        end else begin
          wait_nxt = wait_r + 1'b1;
        end
      end
      S_RS_LOW: if (pend) step_nxt = S_ST_A;
      S_RX_LOW: if (pend) step_nxt = S_RX_HIGH;
      S_RX_HIGH: begin
        if (ph == '0) sh_nxt = {sh[6:0], item.sda_in};
        if (pend) begin
          if (bit_r == 3'd7) begin
            bit_nxt = '0; rx_nxt = sh_nxt; step_nxt = S_NACK_LOW;
          end else begin
            bit_nxt = bit_r + 1'b1; step_nxt = S_RX_LOW;
          end
        end
      end
      S_NACK_LOW: if (pend) step_nxt = S_NACK_HIGH;
      S_NACK_HIGH: if (pend) step_nxt = S_SP_A;
      S_SP_A: if (pend) step_nxt = S_SP_B;
      S_SP_B: if (pend) begin
        if (kind == MODE_PWM && !err && bidx < PWM_LAST_BYTE) begin
          byte_nxt = bidx + 1'b1; step_nxt = S_ST_A;
        end else begin
          step_nxt = S_FIN;
        end
      end
      S_FIN: begin
        ph_nxt = '0; step_nxt = S_IDLE;
      end
      default: begin
        ph_nxt = '0; step_nxt = S_IDLE;
      end
    endcase
    // A new byte is loaded only when bit setup is entered from outside the bit loop.
    if (step_nxt == S_TX_SETUP && st != S_TX_LOW && st != S_TX_SETUP) begin
      sh_nxt = nb; bit_nxt = '0;
    end
    lreg_nxt = lreg; ldat_nxt = ldat; lon_nxt = lon; loff_nxt = loff; kind_nxt = kind;
    res.read_data = rx_nxt;
    res.ack_error = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE; bit_r <= '0; byte_r <= '0; ph_r <= '0; wait_r <= '0;
      sh_r <= '0; rx_r <= '0; lreg_r <= '0; ldat_r <= '0; lon_r <= '0;
      loff_r <= '0; err_r <= 1'b0; kind_r <= MODE_TICK;
    end else if (tick) begin
      step_r <= step_nxt; bit_r <= bit_nxt; byte_r <= byte_nxt; ph_r <= ph_nxt;
      wait_r <= wait_nxt; sh_r <= sh_nxt; rx_r <= rx_nxt; lreg_r <= lreg_nxt;
      ldat_r <= ldat_nxt; lon_r <= lon_nxt; loff_r <= loff_nxt; err_r <= err_nxt;
      kind_r <= kind_nxt;
    end
  end
endmodule

@@ hdl/i2c_register_access_master_core.sv @@
// ----------------------------------------------------------------------------
// I2C register access master core
// Tick-driven I2C master for register write, register read and PWM setup.
// ----------------------------------------------------------------------------
// Each request is one bus tick and yields exactly one result with the line
// levels and status of that tick. The sequencer takes one request per clock
// cycle; results go into a queue of QueueDepth entries (two by default), so
// a request is taken whenever that queue has room and a full queue only
// stalls the input for as long as the consumer holds off pop. Configuration
// is written through cfg_we into a register that the sequencer reads.
module i2c_register_access_master_core
  import i2cra_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  in_item_t           in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output out_item_t          out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data
);
  cfg_t      cfg_r, cfg_nxt;
  out_item_t res;
  logic      tick;

  assign tick = in_push && !in_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_DEV_ADDR: cfg_nxt.device_address = cfg_data[6:0];
        CFG_ACK_TMO: cfg_nxt.ack_timeout = cfg_data;
        CFG_PHASE: cfg_nxt.phase_ticks = cfg_data;
        CFG_PWM_BASE: cfg_nxt.pwm_base_register = cfg_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{device_address: 7'd64, ack_timeout: DEFAULT_ACK_TIMEOUT,
                 phase_ticks: 8'd2, pwm_base_register: 8'd6};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  i2cra_seq u_seq (
    .clk(clk), .rst_n(rst_n), .tick(tick), .item(in_data), .cfg(cfg_r), .res(res)
  );

  i2cra_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(tick), .din(res), .full(in_full),
    .pop(out_pop), .empty(out_empty), .dout(out_data)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    tick && res.done_res |-> !res.busy_res)
    else $error("done with busy");
  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    tick && !res.busy_res |-> res.scl_level && !res.sda_pull_low)
    else $error("idle lines not released");
  a_no_empty_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> !out_empty)
    else $error("result lost");
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C register access master regression
// Drives bus ticks and commands into the core, predicts every tick's line
// levels and status, and checks them against the core under random stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cra_pkg::*;

  localparam int unsigned IdleLimit = 5000;

  typedef struct {
    in_item_t  req;
    int        reps;
    bit        chk;
    out_item_t want;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  in_item_t   in_data;
  logic       out_empty;
  logic       out_pop;
  out_item_t  out_data;
  logic       cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  i2c_register_access_master_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // Bus sequencer model state.
  cfg_t        bus_cfg;
  seq_t        bus_step;
  logic [2:0]  bit_pos;
  logic [3:0]  byte_pos;
  logic [8:0]  phase_cnt;
  logic [7:0]  poll_cnt;
  logic [7:0]  shreg;
  logic [7:0]  rx_byte;
  logic [7:0]  lat_reg;
  logic [7:0]  lat_data;
  logic [15:0] lat_on;
  logic [15:0] lat_off;
  logic        err_flag;
  logic [1:0]  op_mode;

  out_item_t   expected_bus_q[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit          target_refuses;
  int unsigned stall_cycle;
  int unsigned stall_mode;

  function automatic bit phase_done(int unsigned dur);
    if (int'(phase_cnt) + 1 >= dur) begin
      phase_cnt = '0;
      return 1'b1;
    end
    phase_cnt = phase_cnt + 9'd1;
    return 1'b0;
  endfunction

  function automatic logic [7:0] next_tx_byte();
    logic [7:0] addr_w;
    logic [1:0] grp;
    addr_w = {bus_cfg.device_address, 1'b0};
    grp = 2'(byte_pos / 3);
    case (op_mode)
      MODE_WRITE: return byte_pos == 0 ? addr_w : (byte_pos == 1 ? lat_reg : lat_data);
      MODE_READ: return byte_pos == 0 ? addr_w : (byte_pos == 1 ? lat_reg : (addr_w | READ_BIT));
      default: begin
        if (byte_pos % 3 == 0) return addr_w;
        if (byte_pos % 3 == 1) return 8'(lat_reg + grp);
        case (grp)
          2'd0: return lat_on[7:0];
          2'd1: return lat_on[15:8];
          2'd2: return lat_off[7:0];
          default: return lat_off[15:8];
        endcase
      end
    endcase
  endfunction

  function automatic void start_byte();
    shreg = next_tx_byte();
    bit_pos = '0;
    bus_step = S_TX_SETUP;
  endfunction

  function automatic void acked();
    if (op_mode == MODE_WRITE) begin
      if (byte_pos < 2) begin
        byte_pos++;
        start_byte();
      end else bus_step = S_SP_A;
    end else if (op_mode == MODE_READ) begin
      if (byte_pos == 0) begin
        byte_pos = 4'd1;
        start_byte();
      end else if (byte_pos == 1) begin
        byte_pos = 4'd2;
        bus_step = S_RS_LOW;
      end else begin
        bit_pos = '0;
        shreg = '0;
        bus_step = S_RX_LOW;
      end
    end else begin
      if (byte_pos % 3 < 2) begin
        byte_pos++;
        start_byte();
      end else bus_step = S_SP_A;
    end
  endfunction

  function automatic void bus_model_reset();
    bus_cfg = '{device_address: 7'd64, ack_timeout: DEFAULT_ACK_TIMEOUT,
                phase_ticks: 8'd2, pwm_base_register: 8'd6};
    bus_step = S_IDLE;
    bit_pos = '0; byte_pos = '0; phase_cnt = '0; poll_cnt = '0;
    shreg = '0; rx_byte = '0; lat_reg = '0; lat_data = '0;
    lat_on = '0; lat_off = '0; err_flag = 1'b0; op_mode = MODE_TICK;
  endfunction

  function automatic void bus_model_write(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    case (idx)
      CFG_DEV_ADDR: bus_cfg.device_address = val[6:0];
      CFG_ACK_TMO: bus_cfg.ack_timeout = val;
      CFG_PHASE: bus_cfg.phase_ticks = val;
      default: bus_cfg.pwm_base_register = val;
    endcase
  endfunction

  function automatic out_item_t predict_bus_tick(in_item_t req);
    out_item_t   res;
    int unsigned p;
    int unsigned p2;
    logic        tx_low;
    p = bus_cfg.phase_ticks == 0 ? 1 : int'(bus_cfg.phase_ticks);
    p2 = 2 * p;
    if (bus_step == S_IDLE && req.mode != MODE_TICK) begin
      op_mode = req.mode;
      lat_reg = req.mode == MODE_PWM ?
                8'(bus_cfg.pwm_base_register + CHANNEL_STRIDE * req.channel) : req.reg_addr;
      lat_data = req.write_data;
      lat_on = req.on_count;
      lat_off = req.off_count;
      err_flag = 1'b0; byte_pos = '0; bit_pos = '0; phase_cnt = '0; poll_cnt = '0;
      bus_step = S_ST_A;
    end
    tx_low = ~shreg[7];
    res = '0;
    res.scl_level = 1'b1;
    res.busy_res = 1'b1;
    case (bus_step)
      S_ST_B: res.sda_pull_low = 1'b1;
      S_TX_SETUP, S_TX_LOW: begin
        res.scl_level = 1'b0;
        res.sda_pull_low = tx_low;
      end
      S_TX_HIGH: res.sda_pull_low = tx_low;
      S_ACK_REL, S_RS_LOW, S_RX_LOW, S_NACK_LOW: res.scl_level = 1'b0;
      S_SP_A: begin
        res.scl_level = 1'b0;
        res.sda_pull_low = 1'b1;
      end
      S_SP_B: res.sda_pull_low = 1'b1;
      S_FIN: begin
        res.busy_res = 1'b0;
        res.done_res = 1'b1;
      end
      S_IDLE: res.busy_res = 1'b0;
      default: ;
    endcase

    case (bus_step)
      S_ST_A: if (phase_done(p2)) bus_step = S_ST_B;
      S_ST_B: if (phase_done(p2)) start_byte();
      S_TX_SETUP: if (phase_done(p)) bus_step = S_TX_HIGH;
      S_TX_HIGH: if (phase_done(p)) bus_step = S_TX_LOW;
      S_TX_LOW: begin
        if (phase_done(p)) begin
          if (bit_pos == 3'd7) begin
            bit_pos = '0;
            bus_step = S_ACK_REL;
          end else begin
            bit_pos++;
            shreg = shreg << 1;
            bus_step = S_TX_SETUP;
          end
        end
      end
      S_ACK_REL: begin
        if (phase_done(p)) begin
          poll_cnt = '0;
          bus_step = S_ACK_POLL;
        end
      end
      S_ACK_POLL: begin
        if (!req.sda_in) begin
          poll_cnt = '0;
          acked();
        end else if (poll_cnt >= bus_cfg.ack_timeout) begin
          err_flag = 1'b1;
          poll_cnt = '0;
          bus_step = S_SP_A;
        end else poll_cnt++;
      end
      S_RS_LOW: if (phase_done(p)) bus_step = S_ST_A;
      S_RX_LOW: if (phase_done(p)) bus_step = S_RX_HIGH;
      S_RX_HIGH: begin
        // The line is sampled on the first high tick of each received bit.
        if (phase_cnt == 0) shreg = {shreg[6:0], req.sda_in};
        if (phase_done(p)) begin
          if (bit_pos == 3'd7) begin
            bit_pos = '0;
            rx_byte = shreg;
            bus_step = S_NACK_LOW;
          end else begin
            bit_pos++;
            bus_step = S_RX_LOW;
          end
        end
      end
      S_NACK_LOW: if (phase_done(p)) bus_step = S_NACK_HIGH;
      S_NACK_HIGH: if (phase_done(p)) bus_step = S_SP_A;
      S_SP_A: if (phase_done(p2)) bus_step = S_SP_B;
      S_SP_B: begin
        if (phase_done(p2)) begin
          if (op_mode == MODE_PWM && !err_flag && byte_pos < PWM_LAST_BYTE) begin
            byte_pos++;
            bus_step = S_ST_A;
          end else bus_step = S_FIN;
        end
      end
      default: begin
        phase_cnt = '0;
        bus_step = S_IDLE;
      end
    endcase
    res.read_data = rx_byte;
    res.ack_error = err_flag;
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_tick(in_item_t req);
    @(negedge clk);
    in_data <= req;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    expected_bus_q.push_back(predict_bus_tick(req));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_bus_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    bus_model_write(idx, val);
  endtask

  function automatic in_item_t random_tick();
    in_item_t req;
    req = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
    if (bus_step == S_IDLE) begin
      req.mode = ($urandom_range(0, 2) == 0) ? MODE_TICK : 2'($urandom_range(1, 3));
      if (req.mode != MODE_TICK) target_refuses = ($urandom_range(0, 7) == 0);
    end else if (bus_step == S_FIN) begin
      // A command on the done tick must still be ignored.
      req.mode = 2'($urandom_range(1, 3));
    end
    if (bus_step == S_ACK_POLL)
      req.sda_in = target_refuses ? 1'b1 : ($urandom_range(0, 15) == 0);
    return req;
  endfunction

  // Receiver: pop with a randomly chosen stall pattern: always, mostly or half the time.
  always @(negedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 128 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_pop <= 1'b1;
      1: out_pop <= ($urandom_range(0, 3) != 0);
      default: out_pop <= ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_bus_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = expected_bus_q.pop_front();
        if (out_data.scl_level !== want.scl_level || out_data.sda_pull_low !== want.sda_pull_low
            || out_data.busy_res !== want.busy_res || out_data.done_res !== want.done_res
            || out_data.read_data !== want.read_data || out_data.ack_error !== want.ack_error) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("i2c_register_access_master_core regression: fail");
      $finish;
    end
  end

  initial begin
    dir_row_t    rows[$];
    in_item_t    ones;
    out_item_t   idle_res;
    out_item_t   start_res;
    out_item_t   err_res;
    int unsigned burst;
    int unsigned gap;
    logic [7:0]  phase_set[5][5];

    mismatch_count = 0;
    idle_cycles = 0;
    stall_cycle = 0;
    stall_mode = 0;
    target_refuses = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_DEV_ADDR;
    cfg_data = '0;
    bus_model_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    ones = '1;
    idle_res = '{scl_level: 1'b1, default: '0};
    start_res = '{scl_level: 1'b1, busy_res: 1'b1, default: '0};
    err_res = '{scl_level: 1'b1, ack_error: 1'b1, default: '0};
    rows.push_back('{'0, 3, 1'b1, idle_res});
    ones.mode = MODE_TICK;
    rows.push_back('{ones, 2, 1'b1, idle_res});
    ones.mode = MODE_WRITE; ones.sda_in = 1'b0;
    rows.push_back('{ones, 1, 1'b1, start_res});
    // Commands while busy are ignored, the last one on the done tick.
    ones.mode = MODE_PWM;
    rows.push_back('{ones, 169, 1'b0, idle_res});
    // Target never acknowledges: abort after the default timeout.
    rows.push_back('{'{mode: MODE_WRITE, sda_in: 1'b1, default: '0}, 1, 1'b1, start_res});
    rows.push_back('{'{sda_in: 1'b1, default: '0}, 320, 1'b0, idle_res});
    rows.push_back('{'0, 1, 1'b1, err_res});
    rows.push_back('{'{mode: MODE_READ, reg_addr: 8'h5a, default: '0}, 1, 1'b1, start_res});
    rows.push_back('{'0, 220, 1'b0, idle_res});
    rows.push_back('{'{mode: MODE_PWM, channel: 4'hf, on_count: 16'hffff, default: '0},
                     1, 1'b1, start_res});
    rows.push_back('{'{mode: MODE_WRITE, default: '0}, 676, 1'b0, idle_res});
    rows.push_back('{'{mode: MODE_PWM, off_count: 16'hffff, default: '0}, 1, 1'b1, start_res});
    rows.push_back('{'{mode: MODE_READ, default: '0}, 1, 1'b0, idle_res});

    foreach (rows[r]) begin
      repeat (rows[r].reps) begin
        send_tick(rows[r].req);
        if (rows[r].chk) expected_bus_q[$] = rows[r].want;
      end
    end

    // Device address, ack timeout, phase ticks, pwm base, random ticks.
    phase_set = '{'{8'd127, 8'd0, 8'd1, 8'd255, 8'd100},
                  '{8'd0, 8'd255, 8'd0, 8'd0, 8'd100},
                  '{8'd85, 8'd1, 8'd3, 8'd200, 8'd100},
                  '{8'd42, 8'd3, 8'd255, 8'd17, 8'd60},
                  '{8'd64, 8'd2, 8'd1, 8'd6, 8'd80}};
    foreach (phase_set[ph]) begin
      // The sender holds off until every request so far has its result.
      drain_results();
      write_cfg(CFG_DEV_ADDR, phase_set[ph][0]);
      write_cfg(CFG_ACK_TMO, phase_set[ph][1]);
      write_cfg(CFG_PHASE, phase_set[ph][2]);
      write_cfg(CFG_PWM_BASE, phase_set[ph][3]);
      @(negedge clk);
      cfg_we <= 1'b0;
      burst = $urandom_range(1, 40);
      repeat (phase_set[ph][4]) begin
        send_tick(random_tick());
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 40);
          gap = (ph % 2 == 0) ? $urandom_range(0, 6) : 0;
          if (gap != 0) begin
            @(negedge clk);
            in_push <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_bus_q.size() == 0) begin
      $display("i2c_register_access_master_core regression: pass");
    end else begin
      $display("i2c_register_access_master_core regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/i2cra_pkg.sv
hdl/i2cra_fifo.sv
hdl/i2cra_seq.sv
hdl/i2c_register_access_master_core.sv
bench/tb_top.sv
